>>> src/owtm_pkg.sv
`default_nettype none

package owtm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_REL,
    PH_PRES_WAIT,
    PH_PRES_LOW,
    PH_W_LOW,
    PH_W_HIGH,
    PH_R_LOW,
    PH_R_WAIT,
    PH_R_REC
  } phase_t;

  typedef enum logic [2:0] {
    OP_END,
    OP_RST,
    OP_WR,
    OP_WRD,
    OP_RD
  } op_t;

  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_RST  = 3'd1;
  localparam logic [2:0] CMD_WR   = 3'd2;
  localparam logic [2:0] CMD_RD   = 3'd3;
  localparam logic [2:0] CMD_TEMP = 3'd4;

  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_POST_RESET    = 3'd1;
  localparam logic [2:0] REG_PRES_WAIT     = 3'd2;
  localparam logic [2:0] REG_PRES_LOW      = 3'd3;
  localparam logic [2:0] REG_SHORT_LOW     = 3'd4;
  localparam logic [2:0] REG_SLOT          = 3'd5;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [2:0] REG_READ_RECOVER  = 3'd7;

  localparam logic [3:0] STEP_TEMP    = 4'd0;
  localparam logic [3:0] STEP_TEMP_LO = 4'd6;
  localparam logic [3:0] STEP_TEMP_HI = 4'd7;
  localparam logic [3:0] STEP_RESET   = 4'd9;
  localparam logic [3:0] STEP_WRITE   = 4'd11;
  localparam logic [3:0] STEP_READ    = 4'd13;

  localparam logic [2:0] LAST_BIT = 3'd7;

  localparam logic [7:0] ROM_SKIP    = 8'hCC;
  localparam logic [7:0] CONVERT_T   = 8'h44;
  localparam logic [7:0] READ_SCRPAD = 8'hBE;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [7:0] post_reset_ticks;
    logic [9:0] presence_wait_limit;
    logic [9:0] presence_low_limit;
    logic [5:0] short_low_ticks;
    logic [7:0] slot_ticks;
    logic [5:0] read_sample_ticks;
    logic [7:0] read_recover_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [9:0]        tick_count;
    logic [2:0]        bit_index;
    logic [7:0]        shift_byte;
    logic [3:0]        step;
    logic [7:0]        low_byte_hold;
    logic              absent_flag;
    logic signed [15:0] temperature_hold;
    logic [7:0]        read_hold;
  } st_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy;
    logic              done;
    logic              absent;
    logic [7:0]        read_value;
    logic signed [15:0] temperature;
  } res_t;

  function automatic op_t prog_op(input logic [3:0] step);
    op_t op;
    case (step)
      4'd0, 4'd3, 4'd9:         op = OP_RST;
      4'd1, 4'd2, 4'd4, 4'd5:   op = OP_WR;
      4'd6, 4'd7, 4'd13:        op = OP_RD;
      4'd11:                    op = OP_WRD;
      default:                  op = OP_END;
    endcase
    return op;
  endfunction

  function automatic logic [7:0] prog_byte(input logic [3:0] step);
    logic [7:0] b;
    case (step)
      4'd1, 4'd4: b = ROM_SKIP;
      4'd2:       b = CONVERT_T;
      4'd5:       b = READ_SCRPAD;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic st_t begin_op(input st_t s_in);
    st_t s;
    s = s_in;
    s.tick_count = '0;
    s.bit_index  = '0;
    case (prog_op(s.step))
      OP_RST: s.phase = PH_RST_LOW;
      OP_WR: begin
        s.shift_byte = prog_byte(s.step);
        s.phase      = PH_W_LOW;
      end
      OP_WRD: s.phase = PH_W_LOW;
      OP_RD: begin
        s.shift_byte = '0;
        s.phase      = PH_R_LOW;
      end
      default: s.phase = PH_IDLE;
    endcase
    return s;
  endfunction

  function automatic st_t finish_op(input st_t s_in);
    st_t s;
    s = s_in;
    if (prog_op(s.step) == OP_RD) begin
      s.read_hold = s.shift_byte;
      if (s.step == STEP_TEMP_LO) begin
        s.low_byte_hold = s.shift_byte;
      end else if (s.step == STEP_TEMP_HI) begin
        s.temperature_hold = $signed({s.shift_byte, s.low_byte_hold});
      end
    end
    s.step = s.step + 4'd1;
    return begin_op(s);
  endfunction

endpackage

`default_nettype wire

>>> src/owtm_cfg.sv
`default_nettype none

module owtm_cfg
  import owtm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [9:0] cfg_data,
  output cfg_t            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks     <= 10'd480;
      cfg.post_reset_ticks    <= 8'd15;
      cfg.presence_wait_limit <= 10'd200;
      cfg.presence_low_limit  <= 10'd240;
      cfg.short_low_ticks     <= 6'd2;
      cfg.slot_ticks          <= 8'd60;
      cfg.read_sample_ticks   <= 6'd11;
      cfg.read_recover_ticks  <= 8'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RESET_LOW:    cfg.reset_low_ticks     <= cfg_data;
        REG_POST_RESET:   cfg.post_reset_ticks    <= cfg_data[7:0];
        REG_PRES_WAIT:    cfg.presence_wait_limit <= cfg_data;
        REG_PRES_LOW:     cfg.presence_low_limit  <= cfg_data;
        REG_SHORT_LOW:    cfg.short_low_ticks     <= cfg_data[5:0];
        REG_SLOT:         cfg.slot_ticks          <= cfg_data[7:0];
        REG_READ_SAMPLE:  cfg.read_sample_ticks   <= cfg_data[5:0];
        REG_READ_RECOVER: cfg.read_recover_ticks  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/owtm_step.sv
`default_nettype none

module owtm_step
  import owtm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] cmd_data,
  input  wire logic       bus_level,
  input  wire cfg_t       cfg,
  output res_t            res
);

  st_t        st;
  st_t        st_next;
  st_t        s0;
  st_t        s;
  logic [9:0] tc1;
  logic [9:0] len;
  logic       hit;
  logic       fin;
  logic       bitv;

  always_comb begin
    s0 = st;
    if (st.phase == PH_IDLE && (cmd inside {[CMD_RST:CMD_TEMP]})) begin
      case (cmd)
        CMD_TEMP: s0.step = STEP_TEMP;
        CMD_RST:  s0.step = STEP_RESET;
        CMD_WR: begin
          s0.step       = STEP_WRITE;
          s0.shift_byte = cmd_data;
        end
        default:  s0.step = STEP_READ;
      endcase
      s0 = begin_op(s0);
    end
  end

  assign bitv = s0.shift_byte[0];
  assign tc1  = s0.tick_count + 10'd1;

  always_comb begin
    case (s0.phase)
      PH_RST_LOW:   len = cfg.reset_low_ticks;
      PH_RST_REL:   len = {2'b00, cfg.post_reset_ticks};
      PH_PRES_WAIT: len = cfg.presence_wait_limit;
      PH_PRES_LOW:  len = cfg.presence_low_limit;
      PH_W_LOW:     len = bitv ? {4'd0, cfg.short_low_ticks} : {2'b00, cfg.slot_ticks};
      PH_W_HIGH:    len = bitv ? {2'b00, cfg.slot_ticks} : {4'd0, cfg.short_low_ticks};
      PH_R_LOW:     len = {4'd0, cfg.short_low_ticks};
      PH_R_WAIT:    len = {4'd0, cfg.read_sample_ticks};
      PH_R_REC:     len = {2'b00, cfg.read_recover_ticks};
      default:      len = '0;
    endcase
  end

  assign hit = (tc1 >= len);

  always_comb begin
    s   = s0;
    fin = 1'b0;
    case (s0.phase)
      PH_RST_LOW, PH_RST_REL, PH_W_LOW, PH_R_LOW: begin
        s.tick_count = hit ? 10'd0 : tc1;
        if (hit) begin
          case (s0.phase)
            PH_RST_LOW: s.phase = PH_RST_REL;
            PH_RST_REL: s.phase = PH_PRES_WAIT;
            PH_W_LOW:   s.phase = PH_W_HIGH;
            default:    s.phase = PH_R_WAIT;
          endcase
        end
      end
      PH_PRES_WAIT: begin
        if (!bus_level) begin
          s.tick_count = '0;
          s.phase      = PH_PRES_LOW;
        end else begin
          s.tick_count = hit ? 10'd0 : tc1;
          if (hit) begin
            s.absent_flag = 1'b1;
            s   = finish_op(s);
            fin = 1'b1;
          end
        end
      end
      PH_PRES_LOW: begin
        if (bus_level) begin
          s.absent_flag = 1'b0;
          s   = finish_op(s);
          fin = 1'b1;
        end else begin
          s.tick_count = hit ? 10'd0 : tc1;
          if (hit) begin
            s.absent_flag = 1'b1;
            s   = finish_op(s);
            fin = 1'b1;
          end
        end
      end
      PH_W_HIGH: begin
        s.tick_count = hit ? 10'd0 : tc1;
        if (hit) begin
          s.shift_byte = {1'b0, s0.shift_byte[7:1]};
          if (s0.bit_index == LAST_BIT) begin
            s   = finish_op(s);
            fin = 1'b1;
          end else begin
            s.bit_index = s0.bit_index + 3'd1;
            s.phase     = PH_W_LOW;
          end
        end
      end
      PH_R_WAIT: begin
        s.tick_count = hit ? 10'd0 : tc1;
        if (hit) begin
          s.shift_byte = {bus_level, s0.shift_byte[7:1]};
          s.phase      = PH_R_REC;
        end
      end
      PH_R_REC: begin
        s.tick_count = hit ? 10'd0 : tc1;
        if (hit) begin
          if (s0.bit_index == LAST_BIT) begin
            s   = finish_op(s);
            fin = 1'b1;
          end else begin
            s.bit_index = s0.bit_index + 3'd1;
            s.phase     = PH_R_LOW;
          end
        end
      end
      default: s.phase = PH_IDLE;
    endcase
    st_next = s;
  end

  always_comb begin
    res.drive_low   = (s0.phase == PH_RST_LOW) || (s0.phase == PH_W_LOW) ||
                      (s0.phase == PH_R_LOW);
    res.busy        = (s0.phase != PH_IDLE);
    res.done        = fin && (s.phase == PH_IDLE);
    res.absent      = s.absent_flag;
    res.read_value  = s.read_hold;
    res.temperature = s.temperature_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase            <= PH_IDLE;
      st.tick_count       <= '0;
      st.bit_index        <= '0;
      st.shift_byte       <= '0;
      st.step             <= '0;
      st.low_byte_hold    <= '0;
      st.absent_flag      <= 1'b0;
      st.temperature_hold <= '0;
      st.read_hold        <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

>>> src/owtm_out.sv
`default_nettype none

module owtm_out
  import owtm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire res_t          res,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic               drive_low,
  output logic               busy_res,
  output logic               done_res,
  output logic               absent,
  output logic [7:0]         read_value,
  output logic signed [15:0] temperature
);

  res_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign drive_low   = held.drive_low;
  assign busy_res    = held.busy;
  assign done_res    = held.done;
  assign absent      = held.absent;
  assign read_value  = held.read_value;
  assign temperature = held.temperature;

endmodule

`default_nettype wire

>>> src/onewire_temperature_master_unit.sv
// A result beat appears on the output register in the cycle after its tick is accepted.
// One tick is taken per cycle unless the input is stalled; the state and result update together on acceptance.
// A tick is taken whenever the output register is empty or its beat is taken in the same cycle.
// Reset clears the bus sequencer to idle, all held values to zero and the timing registers
// to their default values; the output register comes out of reset empty.
`default_nettype none

module onewire_temperature_master_unit
  import owtm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    cmd,
  input  wire logic [7:0]    cmd_data,
  input  wire logic          bus_level,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               drive_low,
  output logic               busy_res,
  output logic               done_res,
  output logic               absent,
  output logic [7:0]         read_value,
  output logic signed [15:0] temperature,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [9:0]    cfg_data
);

  cfg_t cfg;
  res_t res;
  logic advance;

  assign in_stall = out_valid && out_stall;
  assign advance  = in_valid && !in_stall;

  owtm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owtm_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cmd       (cmd),
    .cmd_data  (cmd_data),
    .bus_level (bus_level),
    .cfg       (cfg),
    .res       (res)
  );

  owtm_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .res         (res),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .drive_low   (drive_low),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .absent      (absent),
    .read_value  (read_value),
    .temperature (temperature)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled while the output register is empty");

  a_accept_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("accepted tick left no result beat");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> busy_res)
    else $error("command finished on a tick that was not busy");

endmodule

`default_nettype wire
